FILE: sv/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg: shared types for the software timer bank
// Operation codes, controller states and the command and status groups that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package stb_pkg;

  // Operation carried with each input item.
  typedef enum logic [1:0] {
    OP_TICK           = 2'd0,
    OP_START_PERIODIC = 2'd1,
    OP_START_ONESHOT  = 2'd2,
    OP_STOP           = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_WALK  = 2'd1,
    ST_FLUSH = 2'd2
  } ctrl_state_e;

  // At most this many expiry reports leave the block per tick.
  localparam int unsigned MaxReports = 8;
  localparam int unsigned RepCntW    = 4;

  // Field widths of the stream payloads.
  localparam int unsigned SlotW     = 3;
  localparam int unsigned IntervalW = 32;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 8;

  typedef struct packed {
    logic wr_en;       // start: write count and reload of the addressed slot
    logic wr_oneshot;  // start is one-shot, so the reload is cleared
    logic stop_en;     // stop: clear the active flag of the addressed slot
    logic tick_begin;  // clear the per-tick report bookkeeping
    logic rd_en;       // read count and reload at the read address
    logic eval_en;     // evaluate the slot under walk and write it back
    logic push_last;   // send the held report marked as last of the tick
  } dp_cmd_t;

  typedef struct packed {
    logic eval_busy;   // the slot under walk needs the output register
    logic pend_valid;  // a report is held back waiting for its successor
    logic out_free;    // the output register can take a new item
  } dp_status_t;

endpackage

FILE: sv/stb_datapath.sv
// ----------------------------------------------------------------------------
// stb_datapath: timer storage, slot evaluation and result register
// Holds the active flags, the count and reload memories, the report that is
// held back until the next one is known, and the output register.
// ----------------------------------------------------------------------------
module stb_datapath
  import stb_pkg::*;
#(
  parameter int unsigned TIMER_SLOTS = 8,
  parameter int unsigned COUNT_BITS  = 32,
  parameter int unsigned SLOT_IW     = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_status_t           status_o,
  input  logic [SlotW-1:0]     slot_i,
  input  logic [IntervalW-1:0] interval_i,
  input  logic [SLOT_IW-1:0]   rd_addr_i,
  input  logic [SLOT_IW-1:0]   ev_idx_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SlotW-1:0]     out_slot_o,
  output logic                 out_running_o,
  output logic                 out_last_o
);

  logic [COUNT_BITS-1:0] rem_mem [TIMER_SLOTS];
  logic [COUNT_BITS-1:0] rld_mem [TIMER_SLOTS];
  logic [COUNT_BITS-1:0] rem_rd_q, rld_rd_q;

  logic [TIMER_SLOTS-1:0] active_q, active_d;

  logic               pend_valid_q, pend_valid_d;
  logic [SlotW-1:0]   pend_slot_q, pend_slot_d;
  logic               pend_run_q, pend_run_d;
  logic [RepCntW-1:0] rep_cnt_q, rep_cnt_d;

  logic             out_valid_q, out_valid_d;
  logic [SlotW-1:0] out_slot_q, out_slot_d;
  logic             out_run_q, out_run_d;
  logic             out_last_q, out_last_d;

  logic [SLOT_IW-1:0]    slot_addr;
  logic [COUNT_BITS-1:0] iv;
  logic                  ev_active, ev_zero, ev_periodic, ev_fire, rep_room;
  logic                  out_free, push;

  logic                  rem_we, rld_we;
  logic [SLOT_IW-1:0]    wr_addr;
  logic [COUNT_BITS-1:0] rem_wdata, rld_wdata;

  assign slot_addr   = SLOT_IW'(slot_i);
  assign iv          = COUNT_BITS'(interval_i);

  assign ev_active   = active_q[ev_idx_i];
  assign ev_zero     = (rem_rd_q == '0);
  assign ev_periodic = (rld_rd_q != '0);
  assign ev_fire     = ev_active && ev_zero;
  assign rep_room    = (rep_cnt_q != RepCntW'(MaxReports));
  assign out_free    = !out_valid_q || out_ready_i;

  assign status_o.eval_busy  = ev_fire && rep_room && pend_valid_q && !out_free;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = out_free;

  // Memory write port: a start writes the addressed slot, the walk writes
  // back the slot under evaluation.
  always_comb begin
    rem_we    = 1'b0;
    rld_we    = 1'b0;
    wr_addr   = ev_idx_i;
    rem_wdata = rem_rd_q - 1'b1;
    rld_wdata = iv;
    if (cmd_i.wr_en) begin
      rem_we    = 1'b1;
      rld_we    = 1'b1;
      wr_addr   = slot_addr;
      rem_wdata = iv;
      rld_wdata = cmd_i.wr_oneshot ? '0 : iv;
    end else if (cmd_i.eval_en && ev_active) begin
      if (!ev_zero) begin
        rem_we = 1'b1;
      end else if (ev_periodic) begin
        rem_we    = 1'b1;
        rem_wdata = rld_rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rem_we) begin
      rem_mem[wr_addr] <= rem_wdata;
    end
    if (rld_we) begin
      rld_mem[wr_addr] <= rld_wdata;
    end
    if (cmd_i.rd_en) begin
      rem_rd_q <= rem_mem[rd_addr_i];
      rld_rd_q <= rld_mem[rd_addr_i];
    end
  end

  always_comb begin
    active_d = active_q;
    if (cmd_i.wr_en) begin
      active_d[slot_addr] = 1'b1;
    end else if (cmd_i.stop_en) begin
      active_d[slot_addr] = 1'b0;
    end else if (cmd_i.eval_en && ev_fire && !ev_periodic) begin
      active_d[ev_idx_i] = 1'b0;
    end
  end

  // A report is held until the next fired slot or the end of the walk shows
  // whether it is the last one of the tick.
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    pend_run_d   = pend_run_q;
    rep_cnt_d    = rep_cnt_q;
    push         = 1'b0;
    out_last_d   = out_last_q;
    if (cmd_i.tick_begin) begin
      pend_valid_d = 1'b0;
      rep_cnt_d    = '0;
    end else if (cmd_i.eval_en && ev_fire && rep_room) begin
      if (pend_valid_q) begin
        push       = 1'b1;
        out_last_d = 1'b0;
      end
      pend_valid_d = 1'b1;
      pend_slot_d  = SlotW'(ev_idx_i);
      pend_run_d   = ev_periodic;
      rep_cnt_d    = rep_cnt_q + 1'b1;
    end else if (cmd_i.push_last) begin
      push         = 1'b1;
      out_last_d   = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_slot_d  = out_slot_q;
    out_run_d   = out_run_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_slot_d  = pend_slot_q;
      out_run_d   = pend_run_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= '0;
      pend_valid_q <= 1'b0;
      rep_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      active_q     <= active_d;
      pend_valid_q <= pend_valid_d;
      rep_cnt_q    <= rep_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_slot_q <= pend_slot_d;
    pend_run_q  <= pend_run_d;
    out_slot_q  <= out_slot_d;
    out_run_q   <= out_run_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_slot_o    = out_slot_q;
  assign out_running_o = out_run_q;
  assign out_last_o    = out_last_q;

endmodule

FILE: sv/stb_ctrl.sv
// ----------------------------------------------------------------------------
// stb_ctrl: sequencer of the software timer bank
// Accepts one item at a time, applies starts and stops at once and walks
// the slots one per cycle on a tick, unless a waiting result halts the walk.
// ----------------------------------------------------------------------------
module stb_ctrl
  import stb_pkg::*;
#(
  parameter int unsigned TIMER_SLOTS = 8,
  parameter int unsigned SLOT_IW     = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  op_e                op_i,
  input  logic [SlotW-1:0]   slot_i,
  input  dp_status_t         status_i,
  output dp_cmd_t            cmd_o,
  output logic [SLOT_IW-1:0] rd_addr_o,
  output logic [SLOT_IW-1:0] ev_idx_o
);

  ctrl_state_e state_q, state_d;
  logic [SLOT_IW-1:0] ev_idx_q, ev_idx_d;
  logic accept, slot_ok, ev_last;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_ok    = (32'(slot_i) < TIMER_SLOTS);
  assign ev_last    = (ev_idx_q == SLOT_IW'(TIMER_SLOTS - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && op_i == OP_TICK) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!status_i.eval_busy && ev_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!status_i.pend_valid || status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    rd_addr_o = '0;
    ev_idx_d  = ev_idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_i)
            OP_TICK: begin
              cmd_o.tick_begin = 1'b1;
              cmd_o.rd_en      = 1'b1;
              ev_idx_d         = '0;
            end
            OP_START_PERIODIC, OP_START_ONESHOT: begin
              cmd_o.wr_en      = slot_ok;
              cmd_o.wr_oneshot = (op_i == OP_START_ONESHOT);
            end
            OP_STOP: cmd_o.stop_en = slot_ok;
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        // The read for the next slot is issued as the current one retires.
        if (!status_i.eval_busy) begin
          cmd_o.eval_en = 1'b1;
          if (!ev_last) begin
            cmd_o.rd_en = 1'b1;
            rd_addr_o   = SLOT_IW'(ev_idx_q + 1'b1);
            ev_idx_d    = SLOT_IW'(ev_idx_q + 1'b1);
          end
        end
      end
      ST_FLUSH: begin
        cmd_o.push_last = status_i.pend_valid && status_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ev_idx_q <= '0;
    end else begin
      state_q  <= state_d;
      ev_idx_q <= ev_idx_d;
    end
  end

  assign ev_idx_o = ev_idx_q;

endmodule

FILE: sv/soft_timer_bank.sv
// ----------------------------------------------------------------------------
// soft_timer_bank: bank of periodic and one-shot software timers
// Start, stop and tick items come in on the slave stream; one item per
// expired timer leaves on the master stream.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries the operation in tuser (tick, start periodic,
//   start one-shot, stop); tdata carries the slot and the interval.
//   A start or stop item is applied in the cycle it is accepted and gives
//   no result; the next item can be taken in the next cycle.
//   A tick walks the slots in ascending order, one slot per cycle while the
//   output does not halt the walk, through the registered read port of the
//   count and reload memories, and a closing step hands the last report to
//   the output register. Each expired slot gives one result item in slot
//   order; tlast marks the last report of the tick, and at most eight
//   reports leave per tick.
//   A result waits in an output register while one more report is held
//   back inside; while the waiting result is not taken the walk halts at
//   the next expired slot after that, and no new item is accepted until
//   the tick is finished.
//   Reset clears all active flags and the controller; counts and reloads
//   are not cleared, as every start writes both. There is no clearing pass.
// ----------------------------------------------------------------------------
module soft_timer_bank
  import stb_pkg::*;
#(
  parameter int unsigned TIMER_SLOTS = 8,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // tdata: slot [2:0], interval [34:3], zero fill [39:35]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // tuser: operation [1:0]
  input  logic [1:0]          s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // tdata: fired_slot [2:0], zero fill [7:3]
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // tuser: still_running [0]
  output logic                m_axis_tuser_o,
  output logic                m_axis_tlast_o
);

  localparam int unsigned SlotIdxW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  dp_cmd_t             cmd;
  dp_status_t          status;
  logic [SlotIdxW-1:0] rd_addr, ev_idx;
  logic [SlotW-1:0]    in_slot, out_slot;
  logic [IntervalW-1:0] in_interval;
  op_e                 in_op;

  assign in_op       = op_e'(s_axis_tuser_i);
  assign in_slot     = s_axis_tdata_i[SlotW-1:0];
  assign in_interval = s_axis_tdata_i[SlotW+IntervalW-1:SlotW];

  stb_ctrl #(
    .TIMER_SLOTS(TIMER_SLOTS),
    .SLOT_IW    (SlotIdxW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .op_i      (in_op),
    .slot_i    (in_slot),
    .status_i  (status),
    .cmd_o     (cmd),
    .rd_addr_o (rd_addr),
    .ev_idx_o  (ev_idx)
  );

  stb_datapath #(
    .TIMER_SLOTS(TIMER_SLOTS),
    .COUNT_BITS (COUNT_BITS),
    .SLOT_IW    (SlotIdxW)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .slot_i       (in_slot),
    .interval_i   (in_interval),
    .rd_addr_i    (rd_addr),
    .ev_idx_i     (ev_idx),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_slot_o   (out_slot),
    .out_running_o(m_axis_tuser_o),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = OutDataW'(out_slot);

endmodule

FILE: sv/stb_checker.sv
// ----------------------------------------------------------------------------
// stb_checker: port checks for the software timer bank
// Watches the two streams of the top level and flags behaviour the bank
// must never show.
// ----------------------------------------------------------------------------
module stb_checker
  import stb_pkg::*;
#(
  parameter int unsigned TIMER_SLOTS = 8,
  parameter int unsigned COUNT_BITS  = 32
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic [InDataW-1:0]  s_axis_tdata_i,
  input logic [1:0]          s_axis_tuser_i,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o,
  input logic                m_axis_tuser_o,
  input logic                m_axis_tlast_o
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // A tick occupies the bank, so it cannot take another item straight away.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == OP_TICK |=>
      !s_axis_tready_o)
    else $error("item taken during a tick walk");

  // Reported slots exist in the bank, and the fill bits stay clear.
  a_out_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      m_axis_tdata_o[OutDataW-1:SlotW] == '0
      && (TIMER_SLOTS >= 8 || 32'(m_axis_tdata_o[SlotW-1:0]) < TIMER_SLOTS))
    else $error("reported slot out of range");

  // Start and stop give no result, so nothing new appears after them.
  a_no_result_on_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i != OP_TICK
      && !m_axis_tvalid_o |=> !m_axis_tvalid_o)
    else $error("result appeared after a start or stop");

endmodule

bind soft_timer_bank stb_checker #(
  .TIMER_SLOTS(TIMER_SLOTS),
  .COUNT_BITS (COUNT_BITS)
) u_stb_checker (.*);
